[hw/rtl/decimal_fixed_point_char_emitter_assert.svh]
// Assertion helpers. Both expect clk and rst in scope.
`ifndef DECIMAL_FIXED_POINT_CHAR_EMITTER_ASSERT_SVH
`define DECIMAL_FIXED_POINT_CHAR_EMITTER_ASSERT_SVH

// Same-cycle implication.
`define DFPCE_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m: check failed");

// Next-cycle implication.
`define DFPCE_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%m: check failed");

`endif

[hw/rtl/dfpce_pkg.sv]
`default_nettype none

package dfpce_pkg;

  localparam int ValueW    = 32;
  localparam int WideW     = ValueW + 2;  // room for 9 * 10^9
  localparam int DigitW    = 4;
  localparam int CharW     = 8;
  localparam int NumDigits = 10;
  localparam int NumChars  = 11;
  localparam int MaxDigit  = 9;
  localparam int DigitIdxW = 4;
  localparam int CharIdxW  = 4;

  // Digit slots 0..2 may be blanked; the point is char slot 4.
  localparam logic [DigitIdxW-1:0] BlankCount = DigitIdxW'(3);
  localparam logic [CharIdxW-1:0]  PointChar  = CharIdxW'(4);
  localparam logic [CharIdxW-1:0]  LastChar   = CharIdxW'(NumChars - 1);

  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharPoint = 8'h2E;
  localparam logic [CharW-1:0] CharZero  = 8'h30;

  typedef logic [DigitW-1:0] digit_t;

  typedef struct packed {
    logic [ValueW-1:0]          rest;
    digit_t [NumDigits-1:0]     digits;
  } work_t;

  // Decimal place weight, most significant digit first.
  function automatic logic [ValueW-1:0] place_weight(input logic [DigitIdxW-1:0] idx);
    logic [ValueW-1:0] w;
    case (idx)
      4'd0:    w = 32'd1000000000;
      4'd1:    w = 32'd100000000;
      4'd2:    w = 32'd10000000;
      4'd3:    w = 32'd1000000;
      4'd4:    w = 32'd100000;
      4'd5:    w = 32'd10000;
      4'd6:    w = 32'd1000;
      4'd7:    w = 32'd100;
      4'd8:    w = 32'd10;
      default: w = 32'd1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dfpce_ifs.sv]
`default_nettype none

interface dfpce_num_if;
  import dfpce_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface dfpce_text_if;
  import dfpce_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] out_char;
  logic             last;
  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/dfpce_digit_stage.sv]
`default_nettype none

`include "decimal_fixed_point_char_emitter_assert.svh"

module dfpce_digit_stage (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [dfpce_pkg::DigitIdxW-1:0]   stage_idx,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire dfpce_pkg::work_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output dfpce_pkg::work_t                       out_data
);
  import dfpce_pkg::*;

  logic [ValueW-1:0] weight;
  logic [WideW-1:0]  mult;
  logic [WideW-1:0]  sub;
  digit_t            dig;
  work_t             result;
  logic              load;

  // Digit = largest k with rest >= k * weight; compares run in parallel.
  always_comb begin
    weight = place_weight(stage_idx);
    dig    = '0;
    sub    = '0;
    mult   = '0;
    for (int k = 1; k <= MaxDigit; k++) begin
      mult = WideW'(weight) * WideW'(k);
      if ({2'b00, in_data.rest} >= mult) begin
        dig = DigitW'(k);
        sub = mult;
      end
    end
    result                   = in_data;
    result.digits[stage_idx] = dig;
    result.rest              = in_data.rest - sub[ValueW-1:0];
  end

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

  `DFPCE_ASSERT_IMPL(a_digit_range, out_valid, out_data.digits[stage_idx] <= DigitW'(MaxDigit))
  `DFPCE_ASSERT_IMPL(a_rest_below_weight, out_valid, out_data.rest < place_weight(stage_idx))
  `DFPCE_ASSERT_NEXT(a_load_sets_valid, load, out_valid)

endmodule

`default_nettype wire

[hw/rtl/dfpce_serializer.sv]
`default_nettype none

`include "decimal_fixed_point_char_emitter_assert.svh"

module dfpce_serializer (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       in_valid,
  output logic                                            in_ready,
  input  wire dfpce_pkg::digit_t [dfpce_pkg::NumDigits-1:0] in_digits,
  dfpce_text_if.source                                    text
);
  import dfpce_pkg::*;

  logic                      buf_v;
  digit_t [NumDigits-1:0]    digits;
  logic [CharIdxW-1:0]       cnt;
  logic                      out_v;
  logic [CharW-1:0]          out_char;
  logic                      out_last;

  logic [DigitIdxW-1:0]      d_idx;
  logic [BlankCount-1:0]     lead;
  logic                      blank;
  logic [CharW-1:0]          ch;
  logic                      load_out;
  logic                      buf_done;
  logic                      accept;

  always_comb begin
    d_idx = (cnt < PointChar) ? DigitIdxW'(cnt) : DigitIdxW'(cnt - 1'b1);
    // lead[j]: digits 0..j are all zero
    lead[0] = (digits[0] == '0);
    for (int j = 1; j < BlankCount; j++) begin
      lead[j] = lead[j-1] && (digits[j] == '0);
    end
    blank = (d_idx < BlankCount) && lead[d_idx[1:0]];
    if (cnt == PointChar) begin
      ch = CharPoint;
    end else if (blank) begin
      ch = CharSpace;
    end else begin
      ch = CharZero + CharW'(digits[d_idx]);
    end
  end

  assign load_out = buf_v && (!out_v || text.ready);
  assign buf_done = load_out && (cnt == LastChar);
  assign in_ready = !buf_v || buf_done;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_v <= 1'b0;
      cnt   <= '0;
      out_v <= 1'b0;
    end else begin
      if (accept) begin
        buf_v <= 1'b1;
        cnt   <= '0;
      end else if (load_out) begin
        cnt <= cnt + 1'b1;
        if (cnt == LastChar) begin
          buf_v <= 1'b0;
        end
      end
      if (load_out) begin
        out_v <= 1'b1;
      end else if (text.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      digits <= in_digits;
    end
    if (load_out) begin
      out_char <= ch;
      out_last <= (cnt == LastChar);
    end
  end

  assign text.valid    = out_v;
  assign text.out_char = out_char;
  assign text.last     = out_last;

  `DFPCE_ASSERT_IMPL(a_cnt_range, buf_v, cnt <= LastChar)
  `DFPCE_ASSERT_NEXT(a_point_slot, load_out && (cnt == PointChar), text.out_char == CharPoint)
  `DFPCE_ASSERT_NEXT(a_last_on_final, buf_done, text.valid && text.last)

endmodule

`default_nettype wire

[hw/rtl/decimal_fixed_point_char_emitter.sv]
`default_nettype none
// Decimal fixed-point character emitter.
// num  (sink): one transfer carries a 32-bit unsigned value.
// text (source): eleven transfers per value, one ASCII char each, in the
//   form DDDD.DDDDDD; leading zeros among the first three digits are sent as
//   spaces, the fourth and all later digits always as digits. last is high on
//   the eleventh char only.
// Path: after its num transfer a value passes ten digit stages, the char
//   buffer and the output register, from which its first char is sent.
// Throughput: one char per cycle while text is not stalled; the char
//   buffer reloads in the cycle its last char moves out, so chars of
//   consecutive values run without gaps. Up to ten values sit in the digit
//   pipeline while the buffer drains.
// Reset (rst, synchronous): drops every value in flight; no clearing pass.
// Stall: when text.ready is low the output char holds, the buffer and then
//   the digit stages fill, and num.ready falls once all are full. Nothing is
//   lost or repeated.
module decimal_fixed_point_char_emitter (
  input  wire logic  clk,
  input  wire logic  rst,
  dfpce_num_if.sink  num,
  dfpce_text_if.source text
);
  import dfpce_pkg::*;

  // Stage k extracts digit k; st_* [k] is the input of stage k.
  logic  [NumDigits:0] st_valid;
  logic  [NumDigits:0] st_ready;
  work_t               st_data [NumDigits+1];

  assign st_valid[0]       = num.valid;
  assign num.ready         = st_ready[0];
  assign st_data[0].rest   = num.value;
  assign st_data[0].digits = '0;

  for (genvar g = 0; g < NumDigits; g++) begin : g_stage
    dfpce_digit_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .stage_idx (DigitIdxW'(g)),
      .in_valid  (st_valid[g]),
      .in_ready  (st_ready[g]),
      .in_data   (st_data[g]),
      .out_valid (st_valid[g+1]),
      .out_ready (st_ready[g+1]),
      .out_data  (st_data[g+1])
    );
  end

  // After the last stage the remainder is zero; only the digits go on.
  dfpce_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid[NumDigits]),
    .in_ready  (st_ready[NumDigits]),
    .in_digits (st_data[NumDigits].digits),
    .text      (text)
  );

endmodule

`default_nettype wire
